[hw/rtl/dfr_pkg.sv]
// ----------------------------------------------------------------------------
// dfr_pkg: shared types and codes of the packet deframer
// Phase codes, result kinds, item and result records.
// ----------------------------------------------------------------------------
package dfr_pkg;

    localparam logic [7:0]  SYNC_BYTE     = 8'hA5;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1600;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

    // item kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    // parse phases
    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_REQ   = 3'd1;
    localparam logic [2:0] PH_CMD   = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CHECK = 3'd5;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] request_number;
        logic [7:0] command_code;
        logic [7:0] payload_length;
        logic [7:0] received_check;
        logic [7:0] computed_check;
        logic       check_ok;
    } result_t;

endpackage

[hw/rtl/dfr_in_stage.sv]
// ----------------------------------------------------------------------------
// dfr_in_stage: input register
// Holds one accepted item until the parser takes it.
// ----------------------------------------------------------------------------
module dfr_in_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          op,
    input  logic [7:0]    rx_byte,
    input  logic          take,
    output logic          item_valid,
    output dfr_pkg::item_t item
);
    import dfr_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // refill in the same cycle the held item leaves
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.op      <= op;
            item_reg.rx_byte <= rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hw/rtl/dfr_parser.sv]
// ----------------------------------------------------------------------------
// dfr_parser: frame parser and idle timer
// Advances the parse state by one item and forms at most one result.
// ----------------------------------------------------------------------------
module dfr_parser
#(
    parameter int MAX_PAYLOAD = 255
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  dfr_pkg::item_t  item,
    input  logic [15:0]     idle_limit,
    output logic            has_result,
    output dfr_pkg::result_t result
);
    import dfr_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    logic [2:0]  phase_reg,   phase_next;
    logic [7:0]  request_reg, request_next;
    logic [7:0]  command_reg, command_next;
    logic [7:0]  length_reg,  length_next;
    logic [7:0]  taken_reg,   taken_next;
    logic [7:0]  xor_reg,     xor_next;
    logic [15:0] idle_reg,    idle_next;
    logic        armed_reg,   armed_next;

    logic [15:0] idle_inc;
    logic [7:0]  limit;
    logic [7:0]  b;

    assign b        = item.rx_byte;
    assign idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 16'd1;
    assign limit    = (length_reg < MAX_LEN) ? length_reg : MAX_LEN;

    always_comb
    begin
        phase_next   = phase_reg;
        request_next = request_reg;
        command_next = command_reg;
        length_next  = length_reg;
        taken_next   = taken_reg;
        xor_next     = xor_reg;
        idle_next    = idle_reg;
        armed_next   = armed_reg;
        has_result   = 1'b0;
        result       = '0;

        if (item.op == OP_TICK)
        begin
            idle_next = idle_inc;
            if (armed_reg && (idle_inc > idle_limit))
            begin
                armed_next  = 1'b0;
                phase_next  = PH_HUNT;
                has_result  = 1'b1;
                result.kind = KIND_TIMEOUT;
            end
        end
        else
        begin
            idle_next  = '0;
            armed_next = 1'b1;
            case (phase_reg)
                PH_REQ:
                begin
                    request_next = b;
                    xor_next     = b;
                    phase_next   = PH_CMD;
                end
                PH_CMD:
                begin
                    command_next = b;
                    xor_next     = xor_reg ^ b;
                    phase_next   = PH_LEN;
                end
                PH_LEN:
                begin
                    length_next = b;
                    xor_next    = xor_reg ^ b;
                    taken_next  = '0;
                    phase_next  = (b != 8'd0) ? PH_DATA : PH_CHECK;
                end
                PH_DATA:
                begin
                    xor_next   = xor_reg ^ b;
                    taken_next = taken_reg + 8'd1;
                    if (({1'b0, taken_reg} + 9'd1) >= {1'b0, limit})
                    begin
                        phase_next = PH_CHECK;
                    end
                    has_result            = 1'b1;
                    result.kind           = KIND_PAYLOAD;
                    result.payload_byte   = b;
                    result.payload_index  = taken_reg;
                    result.request_number = request_reg;
                    result.command_code   = command_reg;
                    result.payload_length = length_reg;
                end
                PH_CHECK:
                begin
                    phase_next            = PH_HUNT;
                    has_result            = 1'b1;
                    result.kind           = KIND_DONE;
                    result.request_number = request_reg;
                    result.command_code   = command_reg;
                    result.payload_length = length_reg;
                    result.received_check = b;
                    result.computed_check = xor_reg;
                    result.check_ok       = (b == xor_reg);
                end
                default:
                begin
                    // hunting, and any phase code with no meaning
                    phase_next = PH_HUNT;
                    if (b == SYNC_BYTE)
                    begin
                        phase_next = PH_REQ;
                        xor_next   = '0;
                        taken_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            request_reg <= '0;
            command_reg <= '0;
            length_reg  <= '0;
            taken_reg   <= '0;
            xor_reg     <= '0;
            idle_reg    <= '0;
            armed_reg   <= 1'b1;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            request_reg <= request_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            taken_reg   <= taken_next;
            xor_reg     <= xor_next;
            idle_reg    <= idle_next;
            armed_reg   <= armed_next;
        end
    end

endmodule

[hw/rtl/dfr_out_stage.sv]
// ----------------------------------------------------------------------------
// dfr_out_stage: result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module dfr_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  dfr_pkg::result_t result,
    output logic             can_take,
    output logic             out_valid,
    input  logic             out_ready,
    output dfr_pkg::result_t held
);
    import dfr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_take = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign held      = result_reg;

endmodule

[hw/rtl/xor_checked_packet_deframer.sv]
// ----------------------------------------------------------------------------
// xor_checked_packet_deframer: sync/length framed packet receiver
// Usage:
//   Input channel (in_valid/in_ready, op, rx_byte) carries either a received
//   byte (op = 0) or one timer tick (op = 1). Output channel (out_valid/
//   out_ready) carries one result per payload byte, one packet-complete
//   result at the check byte, or one timeout result.
//   cfg_wr_en/cfg_wr_data write the idle tick limit (reset value 1600); write
//   it only while no transfer is in flight.
//   Path: input transfer into the input register, parse logic, result
//   register, out_valid; a stalled result register holds the item back.
//   Throughput: one item per cycle while the result register is empty or
//   out_ready is high; the parse step is one pass of logic between the
//   input register and the result register.
//   Reset: hunting for sync, header and check state zero, idle count zero,
//   timeout armed, both registers empty.
//   Receiver stall: the result register holds; an empty input register still
//   takes one more item, then in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module xor_checked_packet_deframer
#(
    parameter int MAX_PAYLOAD = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  payload_index,
    output logic [7:0]  request_number,
    output logic [7:0]  command_code,
    output logic [7:0]  payload_length,
    output logic [7:0]  received_check,
    output logic [7:0]  computed_check,
    output logic        check_ok
);
    import dfr_pkg::*;

    logic [15:0] timeout_reg;
    logic        item_valid;
    item_t       item;
    logic        can_take;
    logic        step;
    logic        has_result;
    result_t     result;
    result_t     held;

    // Timeout limit register: no handshake, written when enabled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // Advance the held item whenever the result register has room for it.
    assign step = item_valid && can_take;

    dfr_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .rx_byte    (rx_byte),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    dfr_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .item       (item),
        .idle_limit (timeout_reg),
        .has_result (has_result),
        .result     (result)
    );

    // Load only items that produce a result; others drop after updating state.
    dfr_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && has_result),
        .result    (result),
        .can_take  (can_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .held      (held)
    );

    assign kind           = held.kind;
    assign payload_byte   = held.payload_byte;
    assign payload_index  = held.payload_index;
    assign request_number = held.request_number;
    assign command_code   = held.command_code;
    assign payload_length = held.payload_length;
    assign received_check = held.received_check;
    assign computed_check = held.computed_check;
    assign check_ok       = held.check_ok;

endmodule

[hw/rtl/dfr_checker.sv]
// ----------------------------------------------------------------------------
// dfr_checker: port-level checks for the packet deframer
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
module dfr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] kind,
    input logic [7:0] payload_byte,
    input logic [7:0] payload_index,
    input logic [7:0] request_number,
    input logic [7:0] command_code,
    input logic [7:0] payload_length,
    input logic [7:0] received_check,
    input logic [7:0] computed_check,
    input logic       check_ok
);
    import dfr_pkg::*;

    // hold a stalled result
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(kind) && $stable(payload_byte))
        else $error("stalled result changed");

    a_check_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DONE |-> check_ok == (received_check == computed_check))
        else $error("check flag disagrees with check bytes");

    a_timeout_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_TIMEOUT |->
            request_number == 8'd0 && command_code == 8'd0 && payload_length == 8'd0
            && payload_index == 8'd0 && check_ok == 1'b0)
        else $error("timeout result carries stale fields");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind != KIND_UNUSED
            && (kind != KIND_PAYLOAD || payload_index < payload_length))
        else $error("payload index beyond length or bad kind");

endmodule

bind xor_checked_packet_deframer dfr_checker u_dfr_checker (.*);

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the XOR-checked packet deframer
// Drives bytes and timer ticks through the input handshake, predicts every
// payload, packet-complete and timeout result with a shadow copy of the
// parser, and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module tb;

    import dfr_pkg::*;

    localparam int MAX_PAYLOAD    = 255;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer at all
    localparam int SETTLE_CYCLES  = 4;     // input register + result register + margin
    localparam int PHASE_ITEMS    = 330;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    logic        op          = OP_BYTE;
    logic [7:0]  rx_byte     = '0;
    logic        out_ready   = 1'b0;

    logic        in_ready;
    logic        out_valid;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  request_number;
    logic [7:0]  command_code;
    logic [7:0]  payload_length;
    logic [7:0]  received_check;
    logic [7:0]  computed_check;
    logic        check_ok;

    always #5 clk = ~clk;

    xor_checked_packet_deframer #(.MAX_PAYLOAD(MAX_PAYLOAD)) uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .payload_index  (payload_index),
        .request_number (request_number),
        .command_code   (command_code),
        .payload_length (payload_length),
        .received_check (received_check),
        .computed_check (computed_check),
        .check_ok       (check_ok)
    );

    // ------------------------------------------------------------------------
    // Shadow parser state and the queue of results it has predicted
    // ------------------------------------------------------------------------
    logic [15:0] sh_timeout;
    logic [2:0]  sh_phase;
    logic [7:0]  sh_req;
    logic [7:0]  sh_cmd;
    logic [7:0]  sh_len;
    logic [7:0]  sh_taken;
    logic [7:0]  sh_xor;
    logic [15:0] sh_idle;
    logic        sh_armed;

    result_t pending_results[$];

    int errors     = 0;
    int items_sent = 0;
    int idle_pct   = 0;   // chance per cycle that the sender leaves a gap
    int stall_pct  = 0;   // chance per cycle that the receiver drops out_ready
    int hold_req   = 0;   // bump to start a long receiver hold-off

    function automatic void shadow_reset();
        sh_timeout = TIMEOUT_RESET;
        sh_phase   = PH_HUNT;
        sh_req     = '0;
        sh_cmd     = '0;
        sh_len     = '0;
        sh_taken   = '0;
        sh_xor     = '0;
        sh_idle    = '0;
        sh_armed   = 1'b1;
    endfunction

    // Advance the shadow parser by one accepted item and queue any result.
    function automatic void deframe_step(input logic o, input logic [7:0] b);
        result_t r;
        int      cap;
        r = '0;
        if (o == OP_TICK)
        begin
            if (sh_idle != IDLE_MAX)
                sh_idle = sh_idle + 16'd1;
            // timeout fires in any phase, hunting included, once until a byte re-arms it
            if (sh_armed && sh_idle > sh_timeout)
            begin
                sh_armed = 1'b0;
                sh_phase = PH_HUNT;
                r.kind   = KIND_TIMEOUT;
                pending_results.push_back(r);
            end
        end
        else
        begin
            sh_idle  = '0;
            sh_armed = 1'b1;
            case (sh_phase)
                PH_REQ:
                begin
                    sh_req   = b;
                    sh_xor   = b;
                    sh_phase = PH_CMD;
                end
                PH_CMD:
                begin
                    sh_cmd   = b;
                    sh_xor   = sh_xor ^ b;
                    sh_phase = PH_LEN;
                end
                PH_LEN:
                begin
                    sh_len   = b;
                    sh_xor   = sh_xor ^ b;
                    sh_taken = '0;
                    // zero length goes straight to the check byte
                    sh_phase = (b != 8'd0) ? PH_DATA : PH_CHECK;
                end
                PH_DATA:
                begin
                    r.kind           = KIND_PAYLOAD;
                    r.payload_byte   = b;
                    r.payload_index  = sh_taken;
                    r.request_number = sh_req;
                    r.command_code   = sh_cmd;
                    r.payload_length = sh_len;
                    sh_xor = sh_xor ^ b;
                    // payload is cut at MAX_PAYLOAD bytes whatever the length says
                    cap = (int'(sh_len) < MAX_PAYLOAD) ? int'(sh_len) : MAX_PAYLOAD;
                    if (int'(sh_taken) + 1 >= cap)
                        sh_phase = PH_CHECK;
                    sh_taken = sh_taken + 8'd1;
                    pending_results.push_back(r);
                end
                PH_CHECK:
                begin
                    sh_phase         = PH_HUNT;
                    r.kind           = KIND_DONE;
                    r.request_number = sh_req;
                    r.command_code   = sh_cmd;
                    r.payload_length = sh_len;
                    r.received_check = b;
                    r.computed_check = sh_xor;
                    r.check_ok       = (b == sh_xor);
                    pending_results.push_back(r);
                end
                default:
                begin
                    // hunting: drop everything but the sync byte
                    sh_phase = PH_HUNT;
                    if (b == SYNC_BYTE)
                    begin
                        sh_phase = PH_REQ;
                        sh_xor   = '0;
                        sh_taken = '0;
                    end
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checker and receiver-side ready driver
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] exp,
                               input logic [7:0] act);
        if (exp !== act)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
            errors++;
        end
    endtask

    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge clk)
    begin
        result_t want;
        // Check the output transfer seen at this edge against the oldest prediction.
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d", $time, kind);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind",           8'(want.kind),       8'(kind));
                check_field("payload_byte",   want.payload_byte,   payload_byte);
                check_field("payload_index",  want.payload_index,  payload_index);
                check_field("request_number", want.request_number, request_number);
                check_field("command_code",   want.command_code,   command_code);
                check_field("payload_length", want.payload_length, payload_length);
                check_field("received_check", want.received_check, received_check);
                check_field("computed_check", want.computed_check, computed_check);
                check_field("check_ok",       8'(want.check_ok),   8'(check_ok));
            end
        end
        // Start a long hold-off when asked, count it down here, else stall at random.
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no transfer happens on either channel for long
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------

    // Offer one item, hold it until the transfer, then predict it.
    task automatic send_item(input logic o, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        deframe_step(o, b);
        items_sent++;
    endtask

    // Ticks carry a random byte to show it is ignored.
    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++)
            send_item(OP_TICK, 8'($urandom_range(255)));
    endtask

    // Drop valid and wait until every predicted result has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        // an item that causes no result may still sit in the pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sh_timeout   = value;
    endtask

    // Send a frame with random header and payload; cut < 0 sends it whole.
    task automatic send_frame(input int len, input bit corrupt, input int cut,
                              input int tick_pct);
        logic [7:0] frame_bytes[$];
        logic [7:0] x;
        logic [7:0] v;
        frame_bytes.push_back(SYNC_BYTE);
        v = 8'($urandom_range(255));
        frame_bytes.push_back(v);
        x = v;
        v = 8'($urandom_range(255));
        frame_bytes.push_back(v);
        x ^= v;
        frame_bytes.push_back(8'(len));
        x ^= 8'(len);
        for (int i = 0; i < len; i++)
        begin
            v = 8'($urandom_range(255));
            frame_bytes.push_back(v);
            x ^= v;
        end
        // flip one bit of the check byte for a corrupt frame
        frame_bytes.push_back(corrupt ? (x ^ (8'd1 << $urandom_range(7))) : x);
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            if (cut >= 0 && i >= cut)
                break;
            if ($urandom_range(99) < tick_pct)
                send_ticks($urandom_range(1, 6));
            send_item(OP_BYTE, frame_bytes[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-built frames: noise, zero length, bad check, sync inside a frame.
    task automatic test_directed_frames();
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        // zero length, all-ones request, good check
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        // two payload bytes at the extremes, bad check
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h02);
        send_item(OP_BYTE, 8'h00);
        send_ticks(1);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h5A);
        // sync value as request and as payload, good check
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, 8'h5A);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, 8'h5B);
        wait_drained();
    endtask

    // Timeout limits at both extremes and a limit hit exactly.
    task automatic test_idle_limits();
        write_timeout(16'd0);
        // first tick after a byte fires mid-frame
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, 8'h12);
        send_ticks(2);
        // and also while hunting
        send_item(OP_BYTE, 8'h34);
        send_ticks(2);
        write_timeout(IDLE_MAX);
        // the largest limit holds the timeout off
        send_item(OP_BYTE, 8'h00);
        send_ticks(3);
        write_timeout(16'd0);
        send_ticks(2);
        write_timeout(16'd2);
        send_item(OP_BYTE, 8'h77);
        send_ticks(4);
        wait_drained();
    endtask

    // Longest payload at the MAX_PAYLOAD cap, plus a one-byte corrupt frame.
    task automatic test_long_frames();
        write_timeout(TIMEOUT_RESET);
        send_frame(255, 1'b0, -1, 0);
        send_frame(1, 1'b1, -1, 0);
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering; the block fills and
    // stalls its input. Then pause the sender until everything has drained.
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_req++;
        send_frame(60, 1'b0, -1, 0);
        wait_drained();
        send_frame(8, 1'b1, -1, 0);
        wait_drained();
    endtask

    // Mostly well-formed frames with random content, plus noise, tick runs,
    // corrupt checks and truncated frames, over four idling phases.
    task automatic test_random_traffic();
        int          target;
        int          roll;
        int          len;
        int          cut;
        bit          corrupt;
        logic [15:0] phase_limit;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 61;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 61;
                end
                default:
                begin
                    idle_pct  = 13;
                    stall_pct = 13;
                end
            endcase
            phase_limit = (p == 1) ? 16'd0 : 16'($urandom_range(1, 8));
            write_timeout(phase_limit);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                begin
                    repeat ($urandom_range(1, 3))
                        send_item(OP_BYTE, 8'($urandom_range(255)));
                end
                else if (roll < 14)
                    send_ticks($urandom_range(1, 10));
                else
                begin
                    len     = ($urandom_range(99) < 4) ? $urandom_range(100, 255)
                                                       : $urandom_range(10);
                    corrupt = ($urandom_range(9) == 0);
                    cut     = ($urandom_range(99) < 10) ? $urandom_range(len + 4) : -1;
                    send_frame(len, corrupt, cut, 8);
                    // resync after a truncated frame by running out the timeout
                    if (cut >= 0)
                        send_ticks(int'(sh_timeout) + 1);
                end
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        shadow_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_idle_limits();
        test_long_frames();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
